// File: sv/manchester_frame_receiver_assert.svh
// assertion macros used by mfr_core of the manchester frame receiver rtl
// no dependencies; included inside module bodies
`ifndef MANCHESTER_FRAME_RECEIVER_ASSERT_SVH
`define MANCHESTER_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication, quiet during reset
`define MFR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mfr assertion failed");

// next-cycle implication, quiet during reset
`define MFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mfr assertion failed");

`endif

// File: sv/mfr_pkg.sv
// types and constants for the manchester frame receiver
// no dependencies
package mfr_pkg;

   localparam int FRAME_BITS = 32;
   localparam int BITS_W     = $clog2(FRAME_BITS + 1);
   localparam logic [BITS_W-1:0] FRAME_BITS_CNT = BITS_W'(FRAME_BITS);

   localparam int WORD_W   = 32;
   localparam int THRESH_W = 16;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   typedef logic [WORD_W-1:0]   word_type;
   typedef logic [THRESH_W-1:0] thresh_type;
   typedef logic [BITS_W-1:0]   bits_type;
   typedef logic [2:0]          msg_code_type;

   localparam thresh_type THRESH_RESET = 16'd750;

   // message type limits
   localparam msg_code_type REQ_TYPE_MAX = 3'd2;
   localparam msg_code_type RSP_TYPE_MIN = 3'd4;

   // register indexes (byte address / 4)
   typedef enum logic [1:0] {
      REG_ENABLE    = 2'd0,
      REG_THRESHOLD = 2'd1,
      REG_SLAVE     = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      PHASE_IDLE  = 3'b001,
      PHASE_START = 3'b010,
      PHASE_RECV  = 3'b100
   } phase_type;

   typedef struct packed {
      logic       enable;
      thresh_type threshold;
      logic       slave;
   } cfg_type;

   typedef struct packed {
      logic     load;
      word_type word;
   } frame_load_type;

endpackage

// File: sv/mfr_if.sv
// valid/ready channel interfaces for edge transactions and frame results
// depends on mfr_pkg
interface mfr_req_if;
   logic              valid;
   logic              ready;
   mfr_pkg::word_type edge_time_us;
   logic              line_level;

   modport source (output valid, output edge_time_us, output line_level, input ready);
   modport sink   (input valid, input edge_time_us, input line_level, output ready);
endinterface

interface mfr_rsp_if;
   logic                  valid;
   logic                  ready;
   mfr_pkg::word_type     frame_word;
   logic                  parity_ok;
   mfr_pkg::msg_code_type message_type;
   logic                  type_ok;

   modport source (output valid, output frame_word, output parity_ok,
                   output message_type, output type_ok, input ready);
   modport sink   (input valid, input frame_word, input parity_ok,
                   input message_type, input type_ok, output ready);
endinterface

// File: sv/mfr_csr.sv
// apb-style configuration registers of the manchester frame receiver
// depends on mfr_pkg
module mfr_csr (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [mfr_pkg::ADDR_W-1:0] paddr,
   input  logic [mfr_pkg::DATA_W-1:0] pwdata,
   output logic [mfr_pkg::DATA_W-1:0] prdata,
   output logic                    pready,
   output mfr_pkg::cfg_type        cfg
);
   import mfr_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index  = reg_index_type'(paddr[3:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_ENABLE:    cfg_in.enable    = pwdata[0];
            REG_THRESHOLD: cfg_in.threshold = pwdata[THRESH_W-1:0];
            REG_SLAVE:     cfg_in.slave     = pwdata[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_ENABLE:    prdata = DATA_W'(cfg_ff.enable);
         REG_THRESHOLD: prdata = DATA_W'(cfg_ff.threshold);
         REG_SLAVE:     prdata = DATA_W'(cfg_ff.slave);
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable    <= 1'b0;
         cfg_ff.threshold <= THRESH_RESET;
         cfg_ff.slave     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: sv/mfr_core.sv
// edge input register and receive state machine of the frame receiver
// depends on mfr_pkg, mfr_req_if and the assertion macro header
module mfr_core (
   input  logic                   clock,
   input  logic                   reset,
   mfr_req_if.sink                req,
   input  mfr_pkg::cfg_type       cfg,
   input  logic                   out_free,
   output mfr_pkg::frame_load_type frame
);
   import mfr_pkg::*;
   `include "manchester_frame_receiver_assert.svh"

   logic       in_valid_ff;
   word_type   in_time_ff;
   logic       in_level_ff;

   phase_type  phase_ff, phase_in;
   word_type   last_ff, last_in;
   bits_type   bits_ff, bits_in;
   word_type   shift_ff, shift_in;

   word_type   elapsed;
   word_type   thresh;
   logic       late_ge;
   logic       late_gt;
   logic       full;
   logic       emit;
   logic       fire;
   logic       take;

   assign elapsed = in_time_ff - last_ff;
   assign thresh  = WORD_W'(cfg.threshold);
   assign late_ge = elapsed >= thresh;
   assign late_gt = elapsed > thresh;
   assign full    = bits_ff == FRAME_BITS_CNT;

   // completing edge needs a free result register
   assign emit = cfg.enable && (phase_ff == PHASE_RECV) && late_gt && full;
   assign fire = in_valid_ff && (!emit || out_free);
   assign take = fire && cfg.enable;

   assign req.ready   = !in_valid_ff || fire;
   assign frame.load  = fire && emit;
   assign frame.word  = shift_ff;

   always_comb begin
      phase_in = phase_ff;
      last_in  = last_ff;
      bits_in  = bits_ff;
      shift_in = shift_ff;
      if (take) begin
         unique case (phase_ff)
            PHASE_START: begin
               if (!late_ge && !in_level_ff) begin
                  phase_in = PHASE_RECV;
                  last_in  = in_time_ff;
                  bits_in  = '0;
                  shift_in = '0;
               end else if (late_ge) begin
                  phase_in = PHASE_IDLE;
               end
            end
            PHASE_RECV: begin
               if (late_gt) begin
                  if (!full) begin
                     // mid-bit edge: bit value is the inverted level
                     shift_in = {shift_ff[WORD_W-2:0], ~in_level_ff};
                     last_in  = in_time_ff;
                     bits_in  = bits_ff + 1'b1;
                  end else begin
                     phase_in = PHASE_IDLE;
                  end
               end
            end
            default: begin
               if (in_level_ff) begin
                  phase_in = PHASE_START;
                  last_in  = in_time_ff;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PHASE_IDLE;
         last_ff     <= '0;
         bits_ff     <= '0;
         shift_ff    <= '0;
      end else begin
         if (req.ready) begin
            in_valid_ff <= req.valid;
         end
         phase_ff <= phase_in;
         last_ff  <= last_in;
         bits_ff  <= bits_in;
         shift_ff <= shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         in_time_ff  <= req.edge_time_us;
         in_level_ff <= req.line_level;
      end
   end

   `MFR_ASSERT_NOW(a_bits_bounded, clock, reset, 1'b1, bits_ff <= FRAME_BITS_CNT)
   `MFR_ASSERT_NEXT(a_idle_after_frame, clock, reset, frame.load, phase_ff == PHASE_IDLE)
   `MFR_ASSERT_NEXT(a_hold_without_edge, clock, reset, !take, $stable(shift_ff) && $stable(last_ff))
   `MFR_ASSERT_NOW(a_stall_only_on_emit, clock, reset, in_valid_ff && !fire, emit && !out_free)

endmodule

// File: sv/mfr_out_reg.sv
// result register with parity and message type checks
// depends on mfr_pkg and mfr_rsp_if
module mfr_out_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  mfr_pkg::frame_load_type frame,
   input  mfr_pkg::cfg_type        cfg,
   output logic                    out_free,
   mfr_rsp_if.source               rsp
);
   import mfr_pkg::*;

   logic         valid_ff, valid_in;
   word_type     word_ff;
   logic         parity_ff;
   msg_code_type type_ff;
   logic         type_ok_ff;

   logic         parity;
   msg_code_type msg;
   logic         fits;

   assign parity = ~^frame.word;
   assign msg    = frame.word[30:28];
   assign fits   = cfg.slave ? (msg <= REQ_TYPE_MAX) : (msg >= RSP_TYPE_MIN);

   assign out_free = !valid_ff || rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      if (frame.load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame.load) begin
         word_ff    <= frame.word;
         parity_ff  <= parity;
         type_ff    <= msg;
         type_ok_ff <= parity && fits;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.frame_word   = word_ff;
   assign rsp.parity_ok    = parity_ff;
   assign rsp.message_type = type_ff;
   assign rsp.type_ok      = type_ok_ff;

endmodule

// File: sv/manchester_frame_receiver.sv
// top level of the manchester frame receiver
// depends on mfr_pkg, mfr_if, mfr_csr, mfr_core, mfr_out_reg
//
//  channel   direction  carries
//  req_ch    in         one line edge: edge_time_us, line_level
//  rsp_ch    out        one frame: frame_word, parity_ok, message_type, type_ok
//  apb       in/out     receive_enable, mid_bit_threshold_us, slave_mode
//
// one edge per cycle unless stalled: an edge is held in the input register, then
// updates the receive state; a completed frame is loaded into the result register
// when its completing edge leaves the input register, and is then valid on rsp_ch.
// reset is synchronous; it clears the state machine, counters and valid flags.
// a frame waiting in the result register stalls the edge that completes the
// next frame, and the edges behind it, until the waiting frame is taken.
module manchester_frame_receiver (
   input  logic                       clock,
   input  logic                       reset,
   mfr_req_if.sink                    req_ch,
   mfr_rsp_if.source                  rsp_ch,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [mfr_pkg::ADDR_W-1:0] paddr,
   input  logic [mfr_pkg::DATA_W-1:0] pwdata,
   output logic [mfr_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);
   import mfr_pkg::*;

   cfg_type        cfg;
   frame_load_type frame;
   logic           out_free;

   mfr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mfr_core u_core (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .cfg      (cfg),
      .out_free (out_free),
      .frame    (frame)
   );

   mfr_out_reg u_out (
      .clock    (clock),
      .reset    (reset),
      .frame    (frame),
      .cfg      (cfg),
      .out_free (out_free),
      .rsp      (rsp_ch)
   );

endmodule
